// ===== hw/rtl/sit_pkg.sv =====
package sit_pkg;

  // Default coordinate width in bits, sign-extended from its top bit.
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Width of one coordinate field on the ports.
  localparam int unsigned FIELD_WIDTH = 32;

  // Tolerance register width.
  localparam int unsigned TOL_WIDTH = 16;

  // Configuration port geometry.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register indexes, taken from the word address.
  localparam logic REG_TOLERANCE = 1'b0;

  // Reset value of the tolerance register.
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

  // Per-check flags that travel beside the squared terms.
  typedef struct packed {
    logic cr_neg;
    logic s_neg;
    logic t_pos;
    logic len_zero;
  } sit_flags_t;

endpackage

// ===== hw/rtl/sit_mul.sv =====
module sit_mul import sit_pkg::*; #(
  parameter int unsigned AW = 8,
  parameter int unsigned BW = 8
) (
  input  logic                     clk_i,
  input  logic                     en1_i,
  input  logic                     en2_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  localparam int unsigned LA = AW / 2;
  localparam int unsigned UA = AW - LA;
  localparam int unsigned LB = BW / 2;
  localparam int unsigned UB = BW - LB;
  localparam int unsigned PW = AW + BW;

  logic [AW-1:0]      ma;
  logic [BW-1:0]      mb;
  logic [LA+LB-1:0]   ll_q;
  logic [LA+UB-1:0]   lh_q;
  logic [UA+LB-1:0]   hl_q;
  logic [UA+UB-1:0]   hh_q;
  logic               neg_q;
  logic [PW-1:0]      sum;
  logic signed [PW-1:0] p_q;

  // Magnitudes of both operands; the sign is applied after the sum.
  assign ma = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign mb = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  // First rank: four partial products of the operand halves.
  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      ll_q  <= ma[LA-1:0] * mb[LB-1:0];
      lh_q  <= ma[LA-1:0] * mb[BW-1:LB];
      hl_q  <= ma[AW-1:LA] * mb[LB-1:0];
      hh_q  <= ma[AW-1:LA] * mb[BW-1:LB];
      neg_q <= a_i[AW-1] ^ b_i[BW-1];
    end
  end

  // Second rank: align and add the partial products, then restore the sign.
  assign sum = PW'(ll_q) + (PW'(hl_q) << LA) + (PW'(lh_q) << LB) + (PW'(hh_q) << (LA + LB));

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      p_q <= neg_q ? $signed(-sum) : $signed(sum);
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/sit_cfg.sv =====
module sit_cfg import sit_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  output logic signed [2*TOL_WIDTH:0] eps2_o
);

  logic [TOL_WIDTH-1:0]  tol_q, tol_d;
  logic [2*TOL_WIDTH:0]  eps2_q;
  logic                  reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[APB_AW-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Tolerance register; writes to other addresses are dropped.
  always_comb begin
    tol_d = tol_q;
    if (wr_en && (reg_idx == REG_TOLERANCE)) begin
      tol_d = pwdata[TOL_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RESET;
      eps2_q <= (2*TOL_WIDTH+1)'(TOL_RESET) * (2*TOL_WIDTH+1)'(TOL_RESET);
    end else begin
      tol_q  <= tol_d;
      eps2_q <= (2*TOL_WIDTH+1)'(tol_q) * (2*TOL_WIDTH+1)'(tol_q);
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TOLERANCE) begin
      prdata = APB_DW'(tol_q);
    end
  end

  assign eps2_o = $signed(eps2_q);

endmodule

// ===== hw/rtl/segment_intersection_test.sv =====
// Segment intersection test. Each word carries two segments as four Q16.16
// endpoints; the block returns one intersects word per input word, in order.
// A new word is accepted every cycle unless a stalled output has filled every
// stage. Between the input and result registers lie two pipelined multiplier
// ranks of two stages each: one forms the cross and dot products, the next
// squares them and scales the segment lengths by the squared tolerance. Each
// pipeline stage holds its word under backpressure and empty stages keep
// filling, so a stalled output does not stop upstream bubbles from closing.
// The tolerance is written over the APB port at address 0 while idle.
module segment_intersection_test import sit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FIELD_WIDTH-1:0]  first_start_x_i,
  input  logic [FIELD_WIDTH-1:0]  first_start_y_i,
  input  logic [FIELD_WIDTH-1:0]  first_end_x_i,
  input  logic [FIELD_WIDTH-1:0]  first_end_y_i,
  input  logic [FIELD_WIDTH-1:0]  second_start_x_i,
  input  logic [FIELD_WIDTH-1:0]  second_start_y_i,
  input  logic [FIELD_WIDTH-1:0]  second_end_x_i,
  input  logic [FIELD_WIDTH-1:0]  second_end_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    intersects_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned CW   = 2 * DW + 1;
  localparam int unsigned SW   = 2 * CW;
  localparam int unsigned EW   = 2 * TOL_WIDTH + 1;
  localparam int unsigned LW   = EW + CW;
  localparam int unsigned CMPW = (SW > LW) ? SW : LW;
  localparam int unsigned NST  = 7;

  logic signed [EW-1:0] eps2;

  sit_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eps2_o  (eps2)
  );

  // Stage control: a stage loads when it is empty or its successor moves on.
  logic [NST:1] v_q;
  logic [NST:1] adv;

  always_comb begin
    adv[NST] = !v_q[NST] || out_ready_i;
    for (int i = NST - 1; i >= 1; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int i = 2; i <= NST; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[1];
  assign out_valid_o = v_q[NST];

  // Coordinates: low W bits of each field, sign-extended.
  // Point order: first start, first end, second start, second end.
  logic [FIELD_WIDTH-1:0] raw_x [4];
  logic [FIELD_WIDTH-1:0] raw_y [4];
  logic signed [W-1:0]    pt_x  [4];
  logic signed [W-1:0]    pt_y  [4];

  assign raw_x[0] = first_start_x_i;
  assign raw_y[0] = first_start_y_i;
  assign raw_x[1] = first_end_x_i;
  assign raw_y[1] = first_end_y_i;
  assign raw_x[2] = second_start_x_i;
  assign raw_y[2] = second_start_y_i;
  assign raw_x[3] = second_end_x_i;
  assign raw_y[3] = second_end_y_i;

  for (genvar p = 0; p < 4; p++) begin : g_pt
    assign pt_x[p] = $signed(W'(raw_x[p]));
    assign pt_y[p] = $signed(W'(raw_y[p]));
  end

  // Stage 1: segment vectors and point offsets from each segment start.
  logic signed [DW-1:0] dx_q [2];
  logic signed [DW-1:0] dy_q [2];
  logic signed [DW-1:0] ux_q [4];
  logic signed [DW-1:0] uy_q [4];

  for (genvar g = 0; g < 2; g++) begin : g_seg_diff
    always_ff @(posedge clk_i) begin
      if (adv[1]) begin
        dx_q[g] <= DW'(pt_x[2*g+1]) - DW'(pt_x[2*g]);
        dy_q[g] <= DW'(pt_y[2*g+1]) - DW'(pt_y[2*g]);
      end
    end
  end

  // Check k tests a point of the other segment against segment k/2.
  for (genvar k = 0; k < 4; k++) begin : g_lane_diff
    localparam int unsigned SEG = k / 2;
    localparam int unsigned PT  = (k < 2) ? k + 2 : k - 2;
    always_ff @(posedge clk_i) begin
      if (adv[1]) begin
        ux_q[k] <= DW'(pt_x[PT]) - DW'(pt_x[2*SEG]);
        uy_q[k] <= DW'(pt_y[PT]) - DW'(pt_y[2*SEG]);
      end
    end
  end

  // Stages 2 and 3: cross and dot product terms, squared segment lengths.
  logic signed [PW-1:0] m_cx [4];
  logic signed [PW-1:0] m_cy [4];
  logic signed [PW-1:0] m_sx [4];
  logic signed [PW-1:0] m_sy [4];
  logic signed [PW-1:0] m_lx [2];
  logic signed [PW-1:0] m_ly [2];

  for (genvar g = 0; g < 2; g++) begin : g_len_mul
    sit_mul #(.AW(DW), .BW(DW)) u_lx (
      .clk_i(clk_i), .en1_i(adv[2]), .en2_i(adv[3]),
      .a_i(dx_q[g]), .b_i(dx_q[g]), .p_o(m_lx[g])
    );
    sit_mul #(.AW(DW), .BW(DW)) u_ly (
      .clk_i(clk_i), .en1_i(adv[2]), .en2_i(adv[3]),
      .a_i(dy_q[g]), .b_i(dy_q[g]), .p_o(m_ly[g])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_prod_mul
    localparam int unsigned SEG = k / 2;
    sit_mul #(.AW(DW), .BW(DW)) u_cx (
      .clk_i(clk_i), .en1_i(adv[2]), .en2_i(adv[3]),
      .a_i(dy_q[SEG]), .b_i(ux_q[k]), .p_o(m_cx[k])
    );
    sit_mul #(.AW(DW), .BW(DW)) u_cy (
      .clk_i(clk_i), .en1_i(adv[2]), .en2_i(adv[3]),
      .a_i(dx_q[SEG]), .b_i(uy_q[k]), .p_o(m_cy[k])
    );
    sit_mul #(.AW(DW), .BW(DW)) u_sx (
      .clk_i(clk_i), .en1_i(adv[2]), .en2_i(adv[3]),
      .a_i(dx_q[SEG]), .b_i(ux_q[k]), .p_o(m_sx[k])
    );
    sit_mul #(.AW(DW), .BW(DW)) u_sy (
      .clk_i(clk_i), .en1_i(adv[2]), .en2_i(adv[3]),
      .a_i(dy_q[SEG]), .b_i(uy_q[k]), .p_o(m_sy[k])
    );
  end

  // Stage 4: cross product, projection, excess over the length, and flags.
  logic signed [CW-1:0] len_d [2];
  logic signed [CW-1:0] len_q [2];
  logic signed [CW-1:0] cr_q  [4];
  logic signed [CW-1:0] s_q   [4];
  logic signed [CW-1:0] t_q   [4];
  sit_flags_t           fl_q4 [4];
  sit_flags_t           fl_q5 [4];
  sit_flags_t           fl_q6 [4];

  for (genvar g = 0; g < 2; g++) begin : g_len
    assign len_d[g] = CW'(m_lx[g]) + CW'(m_ly[g]);
    always_ff @(posedge clk_i) begin
      if (adv[4]) begin
        len_q[g] <= len_d[g];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_terms
    localparam int unsigned SEG = k / 2;
    logic signed [CW-1:0] cr_d;
    logic signed [CW-1:0] s_d;
    logic signed [CW-1:0] t_d;

    assign cr_d = CW'(m_cx[k]) - CW'(m_cy[k]);
    assign s_d  = CW'(m_sx[k]) + CW'(m_sy[k]);
    assign t_d  = s_d - len_d[SEG];

    always_ff @(posedge clk_i) begin
      if (adv[4]) begin
        cr_q[k]           <= cr_d;
        s_q[k]            <= s_d;
        t_q[k]            <= t_d;
        fl_q4[k].cr_neg   <= cr_d[CW-1];
        fl_q4[k].s_neg    <= s_d[CW-1];
        fl_q4[k].t_pos    <= !t_d[CW-1] && (t_d != '0);
        fl_q4[k].len_zero <= (len_d[SEG] == '0);
      end
      if (adv[5]) begin
        fl_q5[k] <= fl_q4[k];
      end
      if (adv[6]) begin
        fl_q6[k] <= fl_q5[k];
      end
    end
  end

  // Stages 5 and 6: squares and tolerance limits.
  logic signed [SW-1:0] sq_cr [4];
  logic signed [SW-1:0] sq_s  [4];
  logic signed [SW-1:0] sq_t  [4];
  logic signed [LW-1:0] lim   [2];

  for (genvar g = 0; g < 2; g++) begin : g_lim_mul
    sit_mul #(.AW(EW), .BW(CW)) u_lim (
      .clk_i(clk_i), .en1_i(adv[5]), .en2_i(adv[6]),
      .a_i(eps2), .b_i(len_q[g]), .p_o(lim[g])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_sq_mul
    sit_mul #(.AW(CW), .BW(CW)) u_sq_cr (
      .clk_i(clk_i), .en1_i(adv[5]), .en2_i(adv[6]),
      .a_i(cr_q[k]), .b_i(cr_q[k]), .p_o(sq_cr[k])
    );
    sit_mul #(.AW(CW), .BW(CW)) u_sq_s (
      .clk_i(clk_i), .en1_i(adv[5]), .en2_i(adv[6]),
      .a_i(s_q[k]), .b_i(s_q[k]), .p_o(sq_s[k])
    );
    sit_mul #(.AW(CW), .BW(CW)) u_sq_t (
      .clk_i(clk_i), .en1_i(adv[5]), .en2_i(adv[6]),
      .a_i(t_q[k]), .b_i(t_q[k]), .p_o(sq_t[k])
    );
  end

  // Stage 7: collinear and overlap decisions, then the result word.
  logic [3:0] coll;
  logic [3:0] proj;
  logic       cross_hit;
  logic       hit;
  logic       intersects_q;

  for (genvar k = 0; k < 4; k++) begin : g_decide
    localparam int unsigned SEG = k / 2;
    logic [CMPW-1:0] lim_w;
    assign lim_w   = CMPW'(lim[SEG]);
    assign coll[k] = CMPW'(sq_cr[k]) <= lim_w;
    assign proj[k] = !fl_q6[k].len_zero
                  && !(fl_q6[k].s_neg && (CMPW'(sq_s[k]) > lim_w))
                  && !(fl_q6[k].t_pos && (CMPW'(sq_t[k]) > lim_w));
  end

  assign cross_hit = (coll == 4'b0000)
                  && (fl_q6[0].cr_neg != fl_q6[1].cr_neg)
                  && (fl_q6[2].cr_neg != fl_q6[3].cr_neg);
  assign hit       = cross_hit || ((coll & proj) != 4'b0000);

  always_ff @(posedge clk_i) begin
    if (adv[NST]) begin
      intersects_q <= hit;
    end
  end

  assign intersects_o = intersects_q;

endmodule

// ===== hw/rtl/sit_checker.sv =====
module sit_checker import sit_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              intersects_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready
);

  // A held result word keeps its value until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(intersects_o))
    else $error("result word changed while stalled");

  // With the output stage empty the whole pipeline can move, so input is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output stage");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

  // A tolerance write is read back by a read of the same register that directly follows it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[APB_AW-1] == REG_TOLERANCE))
    ##1 (psel && !pwrite && (paddr[APB_AW-1] == REG_TOLERANCE))
    |-> prdata[TOL_WIDTH-1:0] == $past(pwdata[TOL_WIDTH-1:0]))
    else $error("tolerance read-back mismatch");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);

// ===== tb/segment_intersection_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the segment test, predicts each intersects word
// from the accepted coordinates and the current tolerance, and compares.
module segment_intersection_checker import sit_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [FIELD_WIDTH-1:0] first_start_x_i,
  input  logic [FIELD_WIDTH-1:0] first_start_y_i,
  input  logic [FIELD_WIDTH-1:0] first_end_x_i,
  input  logic [FIELD_WIDTH-1:0] first_end_y_i,
  input  logic [FIELD_WIDTH-1:0] second_start_x_i,
  input  logic [FIELD_WIDTH-1:0] second_start_y_i,
  input  logic [FIELD_WIDTH-1:0] second_end_x_i,
  input  logic [FIELD_WIDTH-1:0] second_end_y_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   intersects_i,
  input  logic [TOL_WIDTH-1:0]   tolerance_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     hits_o
);

  typedef logic signed [255:0] wide_t;

  bit hit_queue[$];

  // Sign of the cross product, or collinear when it lies within tolerance.
  typedef enum logic [1:0] {SIDE_ON, SIDE_POS, SIDE_NEG} side_e;

  function automatic side_e side_of(wide_t px, wide_t py, wide_t qx, wide_t qy,
                                    wide_t rx, wide_t ry, wide_t eps2);
    wide_t dx, dy, cr, len2;
    dx = qx - px;
    dy = qy - py;
    cr = dy * (rx - qx) - dx * (ry - qy);
    len2 = dx * dx + dy * dy;
    if (cr * cr <= eps2 * len2) return SIDE_ON;
    return (cr < 0) ? SIDE_NEG : SIDE_POS;
  endfunction

  // Projection of p->q onto p->r lies within [-eps, |pr| + eps].
  function automatic bit lies_along(wide_t px, wide_t py, wide_t qx, wide_t qy,
                                    wide_t rx, wide_t ry, wide_t eps2);
    wide_t ax, ay, bx, by, s, len2, lim, t;
    ax = qx - px;
    ay = qy - py;
    bx = rx - px;
    by = ry - py;
    s = ax * bx + ay * by;
    len2 = bx * bx + by * by;
    if (len2 == 0) return 1'b0;
    lim = eps2 * len2;
    if (s < 0 && !(s * s <= lim)) return 1'b0;
    t = s - len2;
    if (t > 0 && !(t * t <= lim)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic wide_t widen(logic [FIELD_WIDTH-1:0] raw);
    return wide_t'(signed'(raw));
  endfunction

  function automatic bit segments_meet(wide_t ax0, wide_t ay0, wide_t ax1,
                                       wide_t ay1, wide_t bx0, wide_t by0,
                                       wide_t bx1, wide_t by1,
                                       logic [TOL_WIDTH-1:0] tol);
    wide_t e, eps2;
    side_e o1, o2, o3, o4;
    e = wide_t'({1'b0, tol});
    eps2 = e * e;
    o1 = side_of(ax0, ay0, ax1, ay1, bx0, by0, eps2);
    o2 = side_of(ax0, ay0, ax1, ay1, bx1, by1, eps2);
    o3 = side_of(bx0, by0, bx1, by1, ax0, ay0, eps2);
    o4 = side_of(bx0, by0, bx1, by1, ax1, ay1, eps2);
    if (o1 != SIDE_ON && o2 != SIDE_ON && o3 != SIDE_ON && o4 != SIDE_ON &&
        o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == SIDE_ON && lies_along(ax0, ay0, bx0, by0, ax1, ay1, eps2)) return 1'b1;
    if (o2 == SIDE_ON && lies_along(ax0, ay0, bx1, by1, ax1, ay1, eps2)) return 1'b1;
    if (o3 == SIDE_ON && lies_along(bx0, by0, ax0, ay0, bx1, by1, eps2)) return 1'b1;
    if (o4 == SIDE_ON && lies_along(bx0, by0, ax1, ay1, bx1, by1, eps2)) return 1'b1;
    return 1'b0;
  endfunction

  initial begin
    fail_count_o = 0;
    hits_o = 0;
    pending_o = 0;
  end

  // Predict on every accepted input word, compare on every accepted result.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        hit_queue.push_back(segments_meet(
          widen(first_start_x_i), widen(first_start_y_i),
          widen(first_end_x_i), widen(first_end_y_i),
          widen(second_start_x_i), widen(second_start_y_i),
          widen(second_end_x_i), widen(second_end_y_i), tolerance_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (hit_queue.size() == 0) begin
          $error("intersects: unexpected word, actual %0b", intersects_i);
          fail_count_o++;
        end else begin
          want = hit_queue.pop_front();
          if (want) hits_o++;
          if (intersects_i !== want) begin
            $error("intersects: expected %0b actual %0b", want, intersects_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = hit_queue.size();
  end

endmodule

// ===== tb/segment_intersection_test_test.sv =====
`timescale 1ns / 1ps

module segment_intersection_test_test;
  import sit_pkg::*;

  localparam int RANDOM_WORDS = 1550;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [FIELD_WIDTH-1:0] coord_q[8];
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   intersects_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic [TOL_WIDTH-1:0]   tolerance_shadow = TOL_RESET;
  int                     fail_count, pending, hits;
  int                     idle_cycles = 0;
  int                     words_sent = 0;
  bit                     stall_on = 1'b0;

  initial for (int i = 0; i < 8; i++) coord_q[i] = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  segment_intersection_test DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_start_x_i(coord_q[0]), .first_start_y_i(coord_q[1]),
    .first_end_x_i(coord_q[2]), .first_end_y_i(coord_q[3]),
    .second_start_x_i(coord_q[4]), .second_start_y_i(coord_q[5]),
    .second_end_x_i(coord_q[6]), .second_end_y_i(coord_q[7]),
    .out_valid_o, .out_ready_i, .intersects_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  segment_intersection_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .first_start_x_i(coord_q[0]), .first_start_y_i(coord_q[1]),
    .first_end_x_i(coord_q[2]), .first_end_y_i(coord_q[3]),
    .second_start_x_i(coord_q[4]), .second_start_y_i(coord_q[5]),
    .second_end_x_i(coord_q[6]), .second_end_y_i(coord_q[7]),
    .out_valid_i(out_valid_o), .out_ready_i, .intersects_i(intersects_o),
    .tolerance_i(tolerance_shadow),
    .fail_count_o(fail_count), .pending_o(pending), .hits_o(hits)
  );

  // Receiver stalls in runs: switch mode now and then, stall often when on.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    out_ready_i <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_tolerance(input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_AW'({REG_TOLERANCE, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tolerance_shadow = value[TOL_WIDTH-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold one word on the channel until it is taken; valid stays up after.
  task automatic send_word(input logic [FIELD_WIDTH-1:0] c[8]);
    for (int i = 0; i < 8; i++) coord_q[i] <= c[i];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  function automatic logic [FIELD_WIDTH-1:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return FIELD_WIDTH'(signed'($urandom_range(0, 64)) - 32) << 16;
      2: return FIELD_WIDTH'(signed'($urandom_range(0, 2000)) - 1000);
      default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Random pair: loose coordinates, or a shared line, or crossing shapes.
  task automatic make_pair(output logic [FIELD_WIDTH-1:0] c[8]);
    int mode, shape;
    int signed bx, by, dx, dy, k0, k1;
    mode = $urandom_range(0, 3);
    shape = $urandom_range(0, 3);
    for (int i = 0; i < 8; i++) c[i] = rnd_coord(mode);
    if (shape == 1) begin
      // Second segment on the first one's line, possibly offset by a hair.
      bx = $urandom_range(0, 4000) - 2000;
      by = $urandom_range(0, 4000) - 2000;
      dx = $urandom_range(0, 200) - 100;
      dy = $urandom_range(0, 200) - 100;
      k0 = $urandom_range(0, 20) - 10;
      k1 = $urandom_range(0, 20) - 10;
      c[0] = bx; c[1] = by; c[2] = bx + 4 * dx; c[3] = by + 4 * dy;
      c[4] = bx + k0 * dx + $urandom_range(0, 4) - 2;
      c[5] = by + k0 * dy + $urandom_range(0, 4) - 2;
      c[6] = bx + k1 * dx; c[7] = by + k1 * dy;
    end else if (shape == 2) begin
      // An X shape around a common center.
      bx = $urandom_range(0, 2000) - 1000;
      by = $urandom_range(0, 2000) - 1000;
      c[0] = bx - $urandom_range(0, 300); c[2] = bx + $urandom_range(0, 300);
      c[1] = by - $urandom_range(0, 300); c[3] = by + $urandom_range(0, 300);
      c[4] = bx - $urandom_range(0, 300); c[6] = bx + $urandom_range(0, 300);
      c[5] = by + $urandom_range(0, 300); c[7] = by - $urandom_range(0, 300);
    end
  endtask

  initial begin
    logic [FIELD_WIDTH-1:0] c[8];
    logic [APB_DW-1:0] tol_set[5];
    tol_set = '{32'h0000_0000, 32'h0001_ffff, 32'h0000_0100, 32'hffff_0003, 32'd1};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words under the reset tolerance: extremes and special cases.
    c = '{default: 32'h7fff_ffff}; send_word(c);
    c = '{default: 32'h8000_0000}; send_word(c);
    c = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}; send_word(c);
    c = '{0, 0, 32'h0004_0000, 32'h0004_0000, 0, 32'h0004_0000, 32'h0004_0000, 0};
    send_word(c);
    c = '{0, 0, 32'h0004_0000, 0, 32'h0005_0000, 0, 32'h0006_0000, 0}; send_word(c);
    c = '{0, 0, 32'h0004_0000, 0, 32'h0004_0000, 0, 32'h0006_0000, 0}; send_word(c);
    c = '{0, 0, 32'h0004_0000, 0, 32'h0004_0001, 0, 32'h0006_0000, 0}; send_word(c);
    c = '{0, 0, 32'h0004_0000, 0, 32'h0004_0002, 0, 32'h0006_0000, 0}; send_word(c);
    c = '{0, 0, 32'h0004_0000, 0, 32'hffff_ffff, 1, 32'hffff_fff0, 1}; send_word(c);
    c = '{5, 5, 5, 5, 5, 5, 5, 5}; send_word(c);
    c = '{5, 5, 5, 5, 0, 0, 10, 10}; send_word(c);
    c = '{0, 0, 10, 10, 5, 5, 5, 5}; send_word(c);
    c = '{0, 0, 0, 32'h0001_0000, 1, 32'h0000_8000, 32'h0001_0000, 32'h0000_8000};
    send_word(c);
    drain();

    // Random phases, one per tolerance setting, including the extremes.
    for (int p = 0; p < 5; p++) begin
      write_tolerance(tol_set[p]);
      for (int n = 0; n < RANDOM_WORDS / 5; n++) begin
        make_pair(c);
        send_word(c);
        if ($urandom_range(0, 15) == 0) drop_valid();
      end
      drain();
    end

    $display("Sent %0d segment pairs over %0d tolerance settings; %0d intersected.",
             words_sent, 6, hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
